### sv/gqr_pkg.sv
// Shared types, constants and codes for the Gouraud quad rasteriser.
package gqr_pkg;

  localparam int unsigned SCREEN_W_DEF  = 320;
  localparam int unsigned SCREEN_H_DEF  = 200;
  localparam int unsigned FRAC_BITS_DEF = 7;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned SHADE_W    = 8;
  localparam int unsigned DIFF_W     = 13;
  localparam int unsigned ROWX_W     = 16;
  localparam int unsigned SDX_W      = 10;
  localparam int unsigned SDY_W      = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = 1;
  localparam int unsigned QCNT_W     = 2;

  localparam logic signed [SDX_W-1:0]  SDX_RESET   = -10'sd40;
  localparam logic signed [SDY_W-1:0]  SDY_RESET   = 9'sd40;
  localparam logic signed [ROWX_W-1:0] FAR_LEFT    = 16'sd32000;
  localparam logic [SHADE_W-1:0]       BRIGHT_MAX  = 8'd127;
  localparam logic [SHADE_W-1:0]       SHADOW_MASK = 8'd63;
  localparam logic [SHADE_W-1:0]       SHADOW_BASE = 8'd128;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_CORNER = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_CORNER,
    OP_DRAW,
    OP_NONE
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHADOW_DX = 1'b0,
    CFG_SHADOW_DY = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_EXEC, ST_RD_W, ST_CLR,
    ST_E_LD0, ST_E_LD1, ST_E_ORD, ST_E_DXG, ST_E_DXW, ST_E_DCG, ST_E_DCW,
    ST_E_RD, ST_E_WR,
    ST_F_RD, ST_F_SET, ST_F_DG, ST_F_DW, ST_F_SHR, ST_F_SHW, ST_F_PIX,
    ST_DONE
  } back_st_e;

  typedef struct packed {
    logic [1:0]                func;
    logic [1:0]                corner;
    logic signed [COORD_W-1:0] xpos;
    logic signed [COORD_W-1:0] ypos;
    logic [SHADE_W-1:0]        shade;
  } in_t;

  typedef struct packed {
    logic [SHADE_W-1:0] pixel;
    logic               in_range;
  } out_t;

  typedef struct packed {
    op_e                       op;
    logic [1:0]                corner;
    logic signed [COORD_W-1:0] xpos;
    logic signed [COORD_W-1:0] ypos;
    logic [SHADE_W-1:0]        shade;
    logic                      on_scr;
  } cmd_t;

  typedef struct packed {
    logic signed [SDX_W-1:0] sdx;
    logic signed [SDY_W-1:0] sdy;
  } shadow_cfg_t;

  typedef struct packed {
    logic signed [ROWX_W-1:0] lx;
    logic signed [ROWX_W-1:0] rx;
    logic [SHADE_W-1:0]       ls;
    logic [SHADE_W-1:0]       rs;
  } row_t;

endpackage

### sv/gouraud_quad_rasterizer_with_shadow_core.sv
// Top level: Gouraud quad rasteriser with cast shadow over a byte frame store.
// Commands are taken one at a time from the queue head, only while no result word is pending.
// Draw: row-table clear, then per sloped edge two divides and a step per row crossed,
//   then per filled row one divide and a shadow and pixel step per column.
// Throughput is set by one frame-store access per fill step and the bit-serial divider.
// Reset: async active low; control, corners and shadow offsets (-40, 40) reset.
module gouraud_quad_rasterizer_with_shadow_core #(
  parameter int unsigned SCREEN_W  = gqr_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H  = gqr_pkg::SCREEN_H_DEF,
  parameter int unsigned FRAC_BITS = gqr_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  gqr_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output gqr_pkg::out_t                     out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gqr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gqr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  gqr_pkg::shadow_cfg_t cfg_q;
  gqr_pkg::cmd_t        cmd;
  logic                 cmd_valid, cmd_pop;

  // config word accepted every cycle; offsets held in one struct
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sdx <= gqr_pkg::SDX_RESET;
      cfg_q.sdy <= gqr_pkg::SDY_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gqr_pkg::CFG_SHADOW_DX: cfg_q.sdx <= cfg_data_i;
        gqr_pkg::CFG_SHADOW_DY: cfg_q.sdy <= cfg_data_i[gqr_pkg::SDY_W-1:0];
        default: ;
      endcase
    end
  end

  // front: decode and queue
  gqr_front #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd)
  );

  // back: frame store access and quad drawing
  gqr_back #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .cfg_i      (cfg_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  a_pop_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  a_pop_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !out_valid_o)
    else $error("command started while a result word is pending");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.in_range) |-> (out_data_o.pixel == '0))
    else $error("out-of-range result carries a pixel value");

  a_pop_leaves_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |=> !out_valid_o)
    else $error("result word appeared in the cycle a command was taken");

endmodule

### sv/gqr_div.sv
// Bit-serial signed divider, quotient truncated toward zero.
module gqr_div #(
  parameter int unsigned NUM_W = 20,
  parameter int unsigned DEN_W = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic             neg_q, neg_d;
  logic [NUM_W-1:0] mag_q, mag_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, mag_q[NUM_W-1]};
    if (start_i) begin
      neg_d = num_i[NUM_W-1];
      mag_d = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      rem_d = '0;
      den_d = den_i;
      cnt_d = CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DEN_W'(trial - {1'b0, den_q});
        mag_d = {mag_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = DEN_W'(trial);
        mag_d = {mag_q[NUM_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? NUM_W'(-mag_q) : mag_q;

endmodule

### sv/gqr_front.sv
// Front end: takes input words, decodes them into commands and queues them.
module gqr_front #(
  parameter int unsigned SCREEN_W = gqr_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H = gqr_pkg::SCREEN_H_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  gqr_pkg::in_t  in_data_i,
  output logic          cmd_valid_o,
  input  logic          cmd_pop_i,
  output gqr_pkg::cmd_t cmd_o
);

  localparam logic signed [gqr_pkg::COORD_W-1:0] W_S = gqr_pkg::COORD_W'(SCREEN_W);
  localparam logic signed [gqr_pkg::COORD_W-1:0] H_S = gqr_pkg::COORD_W'(SCREEN_H);

  gqr_pkg::cmd_t                     q_mem [gqr_pkg::QDEPTH];
  logic [gqr_pkg::QPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [gqr_pkg::QCNT_W-1:0]        cnt_q;
  gqr_pkg::cmd_t                     cmd_in;
  logic                              push, pop;

  always_comb begin
    cmd_in.corner = in_data_i.corner;
    cmd_in.xpos   = in_data_i.xpos;
    cmd_in.ypos   = in_data_i.ypos;
    cmd_in.shade  = in_data_i.shade;
    cmd_in.on_scr = !in_data_i.xpos[gqr_pkg::COORD_W-1] && (in_data_i.xpos < W_S) &&
                    !in_data_i.ypos[gqr_pkg::COORD_W-1] && (in_data_i.ypos < H_S);
    case (in_data_i.func)
      gqr_pkg::FUNC_WRITE:  cmd_in.op = gqr_pkg::OP_WRITE;
      gqr_pkg::FUNC_READ:   cmd_in.op = gqr_pkg::OP_READ;
      gqr_pkg::FUNC_CORNER: cmd_in.op = (in_data_i.corner == 2'd3) ? gqr_pkg::OP_DRAW
                                                                   : gqr_pkg::OP_CORNER;
      default:              cmd_in.op = gqr_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o  = (cnt_q == gqr_pkg::QCNT_W'(gqr_pkg::QDEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cmd_in;
  end

endmodule

### sv/gqr_back.sv
// Back end: frame store, row extent table, edge walker and span filler.
module gqr_back #(
  parameter int unsigned SCREEN_W  = gqr_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H  = gqr_pkg::SCREEN_H_DEF,
  parameter int unsigned FRAC_BITS = gqr_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  gqr_pkg::cmd_t        cmd_i,
  output logic                 cmd_pop_o,
  input  gqr_pkg::shadow_cfg_t cfg_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gqr_pkg::out_t        out_data_o
);

  localparam int unsigned FA_W  = $clog2(SCREEN_W * SCREEN_H);
  localparam int unsigned ROW_W = $clog2(SCREEN_H);
  localparam int unsigned COL_W = $clog2(SCREEN_W);
  localparam int unsigned CW    = gqr_pkg::COORD_W;
  localparam int unsigned DW    = gqr_pkg::DIFF_W;
  localparam int unsigned SW    = gqr_pkg::SHADE_W;
  localparam int unsigned XW    = gqr_pkg::ROWX_W;
  localparam int unsigned NUM_W = DW + FRAC_BITS;
  localparam int unsigned ACC_W = NUM_W + 2;
  localparam logic signed [DW-1:0] W_S   = DW'(SCREEN_W);
  localparam logic signed [DW-1:0] H_S   = DW'(SCREEN_H);
  localparam logic signed [CW-1:0] HM1_S = CW'(SCREEN_H - 1);

  function automatic logic [FA_W-1:0] fa(input logic [ROW_W-1:0] r,
                                         input logic [COL_W-1:0] c);
    return FA_W'(r * SCREEN_W) + FA_W'(c);
  endfunction

  // storage
  logic [SW-1:0]  fmem [SCREEN_W * SCREEN_H];
  gqr_pkg::row_t  rmem [SCREEN_H];
  logic           fm_we;
  logic [FA_W-1:0] fm_waddr, fm_raddr;
  logic [SW-1:0]  fm_wdata, fm_rd_q;
  logic           rm_we;
  logic [ROW_W-1:0] rm_waddr, rm_raddr;
  gqr_pkg::row_t  rm_wdata, rm_rd_q;

  // control
  gqr_pkg::back_st_e st_q, st_d;
  logic              out_valid_q, out_valid_d;
  gqr_pkg::out_t     out_q, out_d;
  logic signed [CW-1:0] cx_q [4], cx_d [4];
  logic signed [CW-1:0] cy_q [4], cy_d [4];
  logic [SW-1:0]        cc_q [4], cc_d [4];

  // datapath
  gqr_pkg::cmd_t        cmd_q, cmd_d;
  logic signed [CW-1:0] ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic [SW-1:0]        ac_q, ac_d, bc_q, bc_d;
  logic [1:0]           e_q, e_d;
  logic [CW-1:0]        span_q, span_d;
  logic signed [NUM_W-1:0] dx_q, dx_d, dc_q, dc_d;
  logic signed [ACC_W-1:0] xf_q, xf_d, cf_q, cf_d;
  logic signed [DW-1:0] wy_q, wy_d, fi_q, fi_d, flast_q, flast_d;
  logic [ROW_W-1:0]     fy_q, fy_d, hi_q, hi_d, clr_q, clr_d, fsy_q, fsy_d;
  logic                 fsh_q, fsh_d;

  // divider
  logic                    div_start, div_done;
  logic signed [NUM_W-1:0] div_num, div_quo;
  logic signed [DW-1:0]    xdiff, cdiff;

  // scratch
  logic signed [CW-1:0] lo, hi;
  logic signed [XW-1:0] xcur, fxa, fxb;
  logic [SW-1:0]        ccur, fca, fcb;
  logic signed [DW-1:0] sx, sy;
  logic [FA_W-1:0]      cmd_addr, sh_addr;
  logic                 do_step, edge_next, row_next, fill_start;
  gqr_pkg::row_t        nrow;

  assign cmd_pop_o   = (st_q == gqr_pkg::ST_IDLE) && cmd_valid_i && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign xdiff   = DW'(bx_q) - DW'(ax_q);
  assign cdiff   = DW'(bc_q) - DW'(ac_q);
  assign div_num = (st_q == gqr_pkg::ST_E_DXG) ? (NUM_W'(xdiff) <<< FRAC_BITS)
                                               : (NUM_W'(cdiff) <<< FRAC_BITS);
  assign div_start = (st_q == gqr_pkg::ST_E_DXG) || (st_q == gqr_pkg::ST_E_DCG) ||
                     (st_q == gqr_pkg::ST_F_DG);

  gqr_div #(
    .NUM_W(NUM_W),
    .DEN_W(CW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (span_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign xcur     = XW'(xf_q >>> FRAC_BITS);
  assign ccur     = SW'(cf_q >>> FRAC_BITS);
  assign cmd_addr = fa(cmd_q.ypos[ROW_W-1:0], cmd_q.xpos[COL_W-1:0]);
  assign sx       = fi_q + DW'(cfg_i.sdx);
  assign sy       = DW'(fy_q) + DW'(cfg_i.sdy);
  assign sh_addr  = fa(fsy_q, sx[COL_W-1:0]);

  always_comb begin
    lo = cy_q[0];
    hi = cy_q[0];
    for (int k = 1; k < 4; k++) begin
      if (cy_q[k] < lo) lo = cy_q[k];
      if (cy_q[k] > hi) hi = cy_q[k];
    end
    if (lo[CW-1]) lo = '0;
    if (hi > HM1_S) hi = HM1_S;
  end

  always_comb begin
    st_d        = st_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cx_d = cx_q;  cy_d = cy_q;  cc_d = cc_q;
    cmd_d = cmd_q;
    ax_d = ax_q;  ay_d = ay_q;  ac_d = ac_q;
    bx_d = bx_q;  by_d = by_q;  bc_d = bc_q;
    e_d = e_q;  span_d = span_q;  dx_d = dx_q;  dc_d = dc_q;
    xf_d = xf_q;  cf_d = cf_q;  wy_d = wy_q;
    fi_d = fi_q;  flast_d = flast_q;  fy_d = fy_q;  hi_d = hi_q;
    clr_d = clr_q;  fsy_d = fsy_q;  fsh_d = fsh_q;
    fm_we = 1'b0;  fm_waddr = cmd_addr;  fm_wdata = cmd_q.shade;  fm_raddr = cmd_addr;
    rm_we = 1'b0;  rm_waddr = clr_q;  rm_raddr = fy_q;
    rm_wdata = '{lx: gqr_pkg::FAR_LEFT, rx: -gqr_pkg::FAR_LEFT, ls: '0, rs: '0};
    nrow = rm_rd_q;
    fxa = rm_rd_q.lx;  fxb = rm_rd_q.rx;  fca = rm_rd_q.ls;  fcb = rm_rd_q.rs;
    do_step = 1'b0;  edge_next = 1'b0;  row_next = 1'b0;  fill_start = 1'b0;

    case (st_q)
      gqr_pkg::ST_IDLE: begin
        if (cmd_pop_o) begin
          cmd_d = cmd_i;
          st_d  = gqr_pkg::ST_EXEC;
        end
      end
      gqr_pkg::ST_EXEC: begin
        out_d = '{pixel: '0, in_range: 1'b0};
        st_d  = gqr_pkg::ST_IDLE;
        case (cmd_q.op)
          gqr_pkg::OP_WRITE: begin
            fm_we          = cmd_q.on_scr;
            out_d.in_range = cmd_q.on_scr;
            out_valid_d    = 1'b1;
          end
          gqr_pkg::OP_READ: begin
            if (cmd_q.on_scr) begin
              st_d = gqr_pkg::ST_RD_W;
            end else begin
              out_valid_d = 1'b1;
            end
          end
          gqr_pkg::OP_CORNER, gqr_pkg::OP_DRAW: begin
            cx_d[cmd_q.corner] = cmd_q.xpos;
            cy_d[cmd_q.corner] = cmd_q.ypos;
            cc_d[cmd_q.corner] = cmd_q.shade;
            if (cmd_q.op == gqr_pkg::OP_DRAW) begin
              clr_d = '0;
              st_d  = gqr_pkg::ST_CLR;
            end else begin
              out_d.in_range = 1'b1;
              out_valid_d    = 1'b1;
            end
          end
          default: out_valid_d = 1'b1;
        endcase
      end
      gqr_pkg::ST_RD_W: begin
        out_d       = '{pixel: fm_rd_q, in_range: 1'b1};
        out_valid_d = 1'b1;
        st_d        = gqr_pkg::ST_IDLE;
      end
      gqr_pkg::ST_CLR: begin
        rm_we = 1'b1;
        if (clr_q == ROW_W'(SCREEN_H - 1)) begin
          e_d  = '0;
          st_d = gqr_pkg::ST_E_LD0;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      gqr_pkg::ST_E_LD0: begin
        ax_d = cx_q[e_q];  ay_d = cy_q[e_q];  ac_d = cc_q[e_q];
        st_d = gqr_pkg::ST_E_LD1;
      end
      gqr_pkg::ST_E_LD1: begin
        bx_d = cx_q[e_q + 2'd1];  by_d = cy_q[e_q + 2'd1];  bc_d = cc_q[e_q + 2'd1];
        st_d = gqr_pkg::ST_E_ORD;
      end
      gqr_pkg::ST_E_ORD: begin
        if (ay_q == by_q) begin
          edge_next = 1'b1;
        end else begin
          if (ay_q > by_q) begin
            ax_d = bx_q;  ay_d = by_q;  ac_d = bc_q;
            bx_d = ax_q;  by_d = ay_q;  bc_d = ac_q;
            span_d = CW'(ay_q - by_q);
          end else begin
            span_d = CW'(by_q - ay_q);
          end
          st_d = gqr_pkg::ST_E_DXG;
        end
      end
      gqr_pkg::ST_E_DXG: st_d = gqr_pkg::ST_E_DXW;
      gqr_pkg::ST_E_DXW: begin
        if (div_done) begin
          dx_d = div_quo;
          st_d = gqr_pkg::ST_E_DCG;
        end
      end
      gqr_pkg::ST_E_DCG: st_d = gqr_pkg::ST_E_DCW;
      gqr_pkg::ST_E_DCW: begin
        if (div_done) begin
          dc_d = div_quo;
          xf_d = ACC_W'(ax_q) <<< FRAC_BITS;
          cf_d = ACC_W'(ac_q) <<< FRAC_BITS;
          wy_d = DW'(ay_q);
          st_d = gqr_pkg::ST_E_RD;
        end
      end
      gqr_pkg::ST_E_RD: begin
        rm_raddr = wy_q[ROW_W-1:0];
        if (!wy_q[DW-1] && (wy_q < H_S)) begin
          st_d = gqr_pkg::ST_E_WR;
        end else begin
          do_step = 1'b1;
        end
      end
      gqr_pkg::ST_E_WR: begin
        if (xcur < rm_rd_q.lx) begin
          nrow.lx = xcur;
          nrow.ls = ccur;
        end
        if (xcur > rm_rd_q.rx) begin
          nrow.rx = xcur;
          nrow.rs = ccur;
        end
        rm_we    = 1'b1;
        rm_waddr = wy_q[ROW_W-1:0];
        rm_wdata = nrow;
        do_step  = 1'b1;
      end
      gqr_pkg::ST_F_RD: begin
        rm_raddr = fy_q;
        st_d     = gqr_pkg::ST_F_SET;
      end
      gqr_pkg::ST_F_SET: begin
        if (rm_rd_q.lx == rm_rd_q.rx) begin
          row_next = 1'b1;
        end else begin
          if (rm_rd_q.lx > rm_rd_q.rx) begin
            fxa = rm_rd_q.rx;  fxb = rm_rd_q.lx;
            fca = rm_rd_q.rs;  fcb = rm_rd_q.ls;
          end
          fsh_d   = !sy[DW-1] && (sy < H_S);
          fsy_d   = sy[ROW_W-1:0];
          fi_d    = DW'(fxa);
          flast_d = (!sy[DW-1] && (sy < H_S)) ? DW'(fxb) : DW'(fxb - 1'b1);
          ac_d    = fca;
          bc_d    = fcb;
          cf_d    = ACC_W'(fca) <<< FRAC_BITS;
          span_d  = CW'(fxb - fxa);
          st_d    = gqr_pkg::ST_F_DG;
        end
      end
      gqr_pkg::ST_F_DG: st_d = gqr_pkg::ST_F_DW;
      gqr_pkg::ST_F_DW: begin
        if (div_done) begin
          dc_d = div_quo;
          st_d = gqr_pkg::ST_F_SHR;
        end
      end
      gqr_pkg::ST_F_SHR: begin
        fm_raddr = sh_addr;
        if (fsh_q && !sx[DW-1] && (sx < W_S)) begin
          st_d = gqr_pkg::ST_F_SHW;
        end else begin
          st_d = gqr_pkg::ST_F_PIX;
        end
      end
      gqr_pkg::ST_F_SHW: begin
        // bright pixels (above 127) under the shadow drop into the band 128 to 191
        fm_waddr = sh_addr;
        fm_wdata = (fm_rd_q & gqr_pkg::SHADOW_MASK) + gqr_pkg::SHADOW_BASE;
        fm_we    = (fm_rd_q > gqr_pkg::BRIGHT_MAX);
        st_d     = gqr_pkg::ST_F_PIX;
      end
      gqr_pkg::ST_F_PIX: begin
        fm_waddr = fa(fy_q, fi_q[COL_W-1:0]);
        fm_wdata = ccur;
        fm_we    = !fi_q[DW-1] && (fi_q < W_S);
        cf_d     = cf_q + ACC_W'(dc_q);
        if (fi_q == flast_q) begin
          row_next = 1'b1;
        end else begin
          fi_d = fi_q + 1'b1;
          st_d = gqr_pkg::ST_F_SHR;
        end
      end
      gqr_pkg::ST_DONE: begin
        out_d       = '{pixel: '0, in_range: 1'b1};
        out_valid_d = 1'b1;
        st_d        = gqr_pkg::ST_IDLE;
      end
      default: st_d = gqr_pkg::ST_IDLE;
    endcase

    if (do_step) begin
      xf_d   = xf_q + ACC_W'(dx_q);
      cf_d   = cf_q + ACC_W'(dc_q);
      wy_d   = wy_q + 1'b1;
      span_d = span_q - 1'b1;
      if (span_q == CW'(1)) begin
        edge_next = 1'b1;
      end else begin
        st_d = gqr_pkg::ST_E_RD;
      end
    end
    if (edge_next) begin
      if (e_q == 2'd3) begin
        fill_start = 1'b1;
      end else begin
        e_d  = e_q + 1'b1;
        st_d = gqr_pkg::ST_E_LD0;
      end
    end
    if (fill_start) begin
      if (lo < hi) begin
        fy_d = lo[ROW_W-1:0];
        hi_d = hi[ROW_W-1:0];
        st_d = gqr_pkg::ST_F_RD;
      end else begin
        st_d = gqr_pkg::ST_DONE;
      end
    end
    if (row_next) begin
      if (ROW_W'(fy_q + 1'b1) == hi_q) begin
        st_d = gqr_pkg::ST_DONE;
      end else begin
        fy_d = fy_q + 1'b1;
        st_d = gqr_pkg::ST_F_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= gqr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        cx_q[k] <= '0;
        cy_q[k] <= '0;
        cc_q[k] <= '0;
      end
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      cc_q        <= cc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    cmd_q   <= cmd_d;
    ax_q    <= ax_d;   ay_q <= ay_d;   ac_q <= ac_d;
    bx_q    <= bx_d;   by_q <= by_d;   bc_q <= bc_d;
    e_q     <= e_d;    span_q <= span_d;
    dx_q    <= dx_d;   dc_q <= dc_d;
    xf_q    <= xf_d;   cf_q <= cf_d;   wy_q <= wy_d;
    fi_q    <= fi_d;   flast_q <= flast_d;
    fy_q    <= fy_d;   hi_q <= hi_d;   clr_q <= clr_d;
    fsy_q   <= fsy_d;  fsh_q <= fsh_d;
  end

  always_ff @(posedge clk_i) begin
    if (fm_we) fmem[fm_waddr] <= fm_wdata;
    fm_rd_q <= fmem[fm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rm_we) rmem[rm_waddr] <= rm_wdata;
    rm_rd_q <= rmem[rm_raddr];
  end

endmodule

### test/tb_top.sv
// Self-checking testbench for the Gouraud quad rasteriser with cast shadow.
`timescale 1ns / 100ps

module tb_top;

  localparam int SCR_W      = 320;
  localparam int SCR_H      = 200;
  localparam int FRAC       = 7;
  localparam int CYCLE_CAP  = 40_000_000;
  localparam int ROW_FREE   = 2047;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  gqr_pkg::in_t                   in_data_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  gqr_pkg::out_t                  out_data_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [gqr_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [gqr_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  gouraud_quad_rasterizer_with_shadow_core uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of frame, row tables, corners and shadow offsets
  // ---------------------------------------------------------------------------
  logic [7:0] frame_px [SCR_W*SCR_H];
  int         edge_lx [SCR_H];
  int         edge_rx [SCR_H];
  logic [7:0] edge_ls [SCR_H];
  logic [7:0] edge_rs [SCR_H];
  int         quad_x [4];
  int         quad_y [4];
  logic [7:0] quad_c [4];
  int         shd_dx = -40;
  int         shd_dy = 40;
  // highest corner row for random quads, so the shadow never lands on the
  // last screen row, which a draw never fills
  int         quad_row_max = ROW_FREE;

  gqr_pkg::in_t  pending_words [$];
  gqr_pkg::out_t expected_words [$];
  int   errors = 0;
  int   cycles = 0;
  int   words_in = 0, words_out = 0, quads_drawn = 0;
  int   send_idle = 0, recv_idle = 0;
  int   hold_off = 0;

  // floor shift right by the fraction width
  function automatic int floor_frac(int v);
    return v >>> FRAC;
  endfunction

  function automatic bit on_scr(int x, int y);
    return x >= 0 && x < SCR_W && y >= 0 && y < SCR_H;
  endfunction

  function automatic int cap_row(int y);
    return (y > quad_row_max) ? quad_row_max : y;
  endfunction

  task automatic walk_side(int xa, int ya, int xb, int yb, int ca, int cb);
    int t, span, dx, dc, xf, cf, x;
    logic [7:0] c;
    if (ya == yb) return;
    if (ya > yb) begin
      t = ya; ya = yb; yb = t;
      t = xa; xa = xb; xb = t;
      t = ca; ca = cb; cb = t;
    end
    span = yb - ya;
    dx = ((xb - xa) * (1 << FRAC)) / span;
    dc = ((cb - ca) * (1 << FRAC)) / span;
    xf = xa * (1 << FRAC);
    cf = ca * (1 << FRAC);
    for (int i = ya; i < yb; i++) begin
      if (i >= 0 && i < SCR_H) begin
        x = floor_frac(xf);
        c = 8'(floor_frac(cf));
        if (x < edge_lx[i]) begin edge_lx[i] = x; edge_ls[i] = c; end
        if (x > edge_rx[i]) begin edge_rx[i] = x; edge_rs[i] = c; end
      end
      xf += dx;
      cf += dc;
    end
  endtask

  task automatic shade_row(int y);
    int xa, xb, ca, cb, sy, sx, t, last, dc, cf;
    bit shadow;
    logic [7:0] b;
    xa = edge_lx[y]; xb = edge_rx[y];
    ca = edge_ls[y]; cb = edge_rs[y];
    sy = y + shd_dy;
    shadow = sy >= 0 && sy < SCR_H;
    if (xa == xb) return;
    if (xa > xb) begin
      t = xa; xa = xb; xb = t;
      t = ca; ca = cb; cb = t;
    end
    dc = ((cb - ca) * (1 << FRAC)) / (xb - xa);
    cf = ca * (1 << FRAC);
    last = shadow ? xb : xb - 1;
    for (int i = xa; i <= last; i++) begin
      if (shadow) begin
        sx = i + shd_dx;
        if (sx >= 0 && sx < SCR_W) begin
          b = frame_px[sy*SCR_W + sx];
          if (b > gqr_pkg::BRIGHT_MAX)
            frame_px[sy*SCR_W + sx] = (b & gqr_pkg::SHADOW_MASK) + gqr_pkg::SHADOW_BASE;
        end
      end
      if (i >= 0 && i < SCR_W) frame_px[y*SCR_W + i] = 8'(floor_frac(cf));
      cf += dc;
    end
  endtask

  task automatic draw_shaded_quad();
    int lo, hi, j;
    for (int i = 0; i < SCR_H; i++) begin
      edge_lx[i] = int'(gqr_pkg::FAR_LEFT);
      edge_rx[i] = -int'(gqr_pkg::FAR_LEFT);
    end
    lo = quad_y[0]; hi = quad_y[0];
    for (int i = 1; i < 4; i++) begin
      if (quad_y[i] < lo) lo = quad_y[i];
      if (quad_y[i] > hi) hi = quad_y[i];
    end
    if (lo < 0) lo = 0;
    if (hi > SCR_H - 1) hi = SCR_H - 1;
    for (int i = 0; i < 4; i++) begin
      j = (i + 1) & 3;
      walk_side(quad_x[i], quad_y[i], quad_x[j], quad_y[j], quad_c[i], quad_c[j]);
    end
    for (int i = lo; i < hi; i++) shade_row(i);
    quads_drawn++;
  endtask

  // work out the answer to one accepted word and queue it
  task automatic predict_word(gqr_pkg::in_t w);
    gqr_pkg::out_t r;
    int x, y;
    x = int'(w.xpos);
    y = int'(w.ypos);
    r = '0;
    case (gqr_pkg::func_e'(w.func))
      gqr_pkg::FUNC_WRITE: if (on_scr(x, y)) begin
        frame_px[y*SCR_W + x] = w.shade;
        r.in_range = 1'b1;
      end
      gqr_pkg::FUNC_READ: if (on_scr(x, y)) begin
        r.pixel = frame_px[y*SCR_W + x];
        r.in_range = 1'b1;
      end
      gqr_pkg::FUNC_CORNER: begin
        quad_x[w.corner] = x;
        quad_y[w.corner] = y;
        quad_c[w.corner] = w.shade;
        r.in_range = 1'b1;
        if (w.corner == 2'd3) draw_shaded_quad();
      end
      default: ;
    endcase
    expected_words.push_back(r);
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch @%0t: %s", $time, what);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued words, idles at random, holds payload while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_word(in_data_i);
        words_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_words.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: long hold-off when asked, else random back-pressure
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // Monitor: each accepted result word against the oldest expectation
  always @(posedge clk_i) begin
    gqr_pkg::out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_out++;
      if (expected_words.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        e = expected_words.pop_front();
        if (out_data_o.pixel !== e.pixel)
          report_mismatch($sformatf("pixel %0d, expected %0d", out_data_o.pixel, e.pixel));
        if (out_data_o.in_range !== e.in_range)
          report_mismatch($sformatf("in_range %0b, expected %0b",
                                    out_data_o.in_range, e.in_range));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(gqr_pkg::func_e f, int c, int x, int y, int s);
    gqr_pkg::in_t w;
    w.func = f;
    w.corner = 2'(c);
    w.xpos = 12'(x);
    w.ypos = 12'(y);
    w.shade = 8'(s);
    pending_words.push_back(w);
  endtask

  task automatic push_quad(int x0, int y0, int x1, int y1, int x2, int y2, int x3, int y3);
    push_word(gqr_pkg::FUNC_CORNER, 0, x0, y0, $urandom_range(255));
    push_word(gqr_pkg::FUNC_CORNER, 1, x1, y1, $urandom_range(255));
    push_word(gqr_pkg::FUNC_CORNER, 2, x2, y2, $urandom_range(255));
    push_word(gqr_pkg::FUNC_CORNER, 3, x3, y3, $urandom_range(255));
  endtask

  // small quad around a random centre, sometimes straddling the screen edge
  task automatic push_small_quad();
    int cx, cy, r;
    cx = $urandom_range(370) - 25;
    cy = $urandom_range(250) - 25;
    r = $urandom_range(30);
    push_quad(cx - $urandom_range(r), cap_row(cy - $urandom_range(r)),
              cx + $urandom_range(r), cap_row(cy - $urandom_range(r)),
              cx + $urandom_range(r), cap_row(cy + $urandom_range(r)),
              cx - $urandom_range(r), cap_row(cy + $urandom_range(r)));
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid_i || expected_words.size() != 0)
      @(posedge clk_i);
  endtask

  // a draw is answered only once it is done; a read queues behind it
  task automatic settle();
    push_word(gqr_pkg::FUNC_READ, 0, 0, 0, 0);
    drain();
    repeat (64) @(posedge clk_i);
  endtask

  task automatic write_reg(gqr_pkg::cfg_idx_e idx, int val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= gqr_pkg::CFG_DATA_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == gqr_pkg::CFG_SHADOW_DX) begin
      shd_dx = int'($signed(gqr_pkg::SDX_W'(val)));
    end else begin
      shd_dy = int'($signed(gqr_pkg::SDY_W'(val)));
      quad_row_max = (shd_dy > 0) ? SCR_H - 1 - shd_dy : ROW_FREE;
    end
  endtask

  task automatic random_words(int n);
    int k, pick, ry;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        push_small_quad();
        k += 4;
      end else if (pick < 55) begin
        push_word(gqr_pkg::FUNC_WRITE, $urandom_range(3), $urandom_range(SCR_W-1),
                  $urandom_range(SCR_H-1), $urandom_range(255));
        k++;
      end else if (pick < 65) begin
        // full-range coordinates: mostly off screen, never the last row
        ry = $urandom_range(4095);
        if (ry == SCR_H - 1) ry = SCR_H - 2;
        push_word($urandom_range(1) ? gqr_pkg::FUNC_WRITE : gqr_pkg::FUNC_READ,
                  $urandom_range(3), $urandom_range(4095), ry, $urandom_range(255));
        k++;
      end else if (pick < 95) begin
        push_word(gqr_pkg::FUNC_READ, $urandom_range(3), $urandom_range(SCR_W-1),
                  $urandom_range(SCR_H-2), $urandom_range(255));
        k++;
      end else begin
        push_word(gqr_pkg::FUNC_NONE, $urandom_range(3), $urandom_range(4095),
                  $urandom_range(4095), $urandom_range(255));
        k++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SCR_H; i++) begin
      edge_lx[i] = int'(gqr_pkg::FAR_LEFT);
      edge_rx[i] = -int'(gqr_pkg::FAR_LEFT);
      edge_ls[i] = '0;
      edge_rs[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      quad_x[i] = 0; quad_y[i] = 0; quad_c[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // One quad past every screen edge fills all rows but the last with a
    // dark-to-bright ramp; the shadow row is kept off screen meanwhile.
    // The last row is only ever read where it was written.
    write_reg(gqr_pkg::CFG_SHADOW_DY, -199);
    push_word(gqr_pkg::FUNC_CORNER, 0, -10, -10, 0);
    push_word(gqr_pkg::FUNC_CORNER, 1, SCR_W + 10, -10, 255);
    push_word(gqr_pkg::FUNC_CORNER, 2, SCR_W + 10, SCR_H + 10, 255);
    push_word(gqr_pkg::FUNC_CORNER, 3, -10, SCR_H + 10, 0);
    drain();

    // Directed: screen corners, off-screen access, spare code, odd quads
    send_idle = 14; recv_idle = 52;
    push_word(gqr_pkg::FUNC_WRITE, 3, 0, 0, 255);
    push_word(gqr_pkg::FUNC_WRITE, 0, SCR_W-1, SCR_H-1, 0);
    push_word(gqr_pkg::FUNC_READ, 1, 0, 0, 0);
    push_word(gqr_pkg::FUNC_READ, 2, SCR_W-1, SCR_H-1, 255);
    push_word(gqr_pkg::FUNC_WRITE, 0, -1, 0, 170);
    push_word(gqr_pkg::FUNC_WRITE, 0, SCR_W, 5, 85);
    push_word(gqr_pkg::FUNC_WRITE, 0, 5, SCR_H, 85);
    push_word(gqr_pkg::FUNC_READ, 0, -2048, 2047, 0);
    push_word(gqr_pkg::FUNC_READ, 0, 2047, -2048, 0);
    push_word(gqr_pkg::FUNC_NONE, 3, 100, 100, 255);
    // flat quad: every edge horizontal, nothing drawn
    push_quad(10, 50, 60, 50, 60, 50, 10, 50);
    // very wide, few rows; corners at the column extremes
    push_quad(-2048, 5, 2047, 6, 2047, 8, -2048, 9);
    // very tall, narrow; corners at the row extremes, corner order reversed
    push_quad(104, 2047, 110, 0, 100, -2048, 96, 100);
    drain();

    // Phase with a long receiver hold-off so the block backs up
    settle();
    write_reg(gqr_pkg::CFG_SHADOW_DX, -319);
    write_reg(gqr_pkg::CFG_SHADOW_DY, -199);
    hold_off = 400;
    random_words(54);
    drain();

    settle();
    write_reg(gqr_pkg::CFG_SHADOW_DX, 319);
    write_reg(gqr_pkg::CFG_SHADOW_DY, 199);
    send_idle = 52; recv_idle = 14;
    random_words(54);
    drain();

    settle();
    write_reg(gqr_pkg::CFG_SHADOW_DX, 0);
    write_reg(gqr_pkg::CFG_SHADOW_DY, 0);
    random_words(54);
    drain();

    settle();
    write_reg(gqr_pkg::CFG_SHADOW_DX, $urandom_range(60) - 30);
    write_reg(gqr_pkg::CFG_SHADOW_DY, $urandom_range(40) - 20);
    send_idle = 0; recv_idle = 0;
    random_words(54);
    drain();

    settle();
    write_reg(gqr_pkg::CFG_SHADOW_DX, -40);
    write_reg(gqr_pkg::CFG_SHADOW_DY, 40);
    random_words(54);
    drain();

    repeat (200) @(posedge clk_i);
    $display("covered: screen-filling quad, %0d words in, %0d results out, %0d quads drawn,",
             words_in, words_out, quads_drawn);
    $display("shadow offsets at both extremes, zero and reset value, with back-pressure");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
sv/gqr_pkg.sv
sv/gqr_div.sv
sv/gqr_front.sv
sv/gqr_back.sv
sv/gouraud_quad_rasterizer_with_shadow_core.sv
test/tb_top.sv
